// File: rtl/dmwtc_pkg.sv
`timescale 1ns / 1ps

package dmwtc_pkg;

  // Fixed field widths
  localparam int ADDR_W = 32;
  localparam int DATA_W = 32;
  localparam int LIDX_W = 12;

  // Stream payload widths
  localparam int S_TDATA_W = 80;  // 77 field bits padded to whole bytes
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 96;
  localparam int M_TUSER_W = 4;

  // Operation carried in s_tuser
  typedef enum logic [1:0] {
    FUNC_READ      = 2'd0,
    FUNC_WRITE     = 2'd1,
    FUNC_SET_VALID = 2'd2,
    FUNC_FILL      = 2'd3
  } func_t;

  // Memory request carried in m_tuser
  typedef enum logic [1:0] {
    MEM_NONE  = 2'd0,
    MEM_READ  = 2'd1,
    MEM_WRITE = 2'd2
  } mem_op_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

endpackage

// File: rtl/dmwtc_ram.sv
`timescale 1ns / 1ps

module dmwtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; read data holds while re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/direct_mapped_write_through_cache_core.sv
`timescale 1ns / 1ps

// Channel  Dir  Handshake         Payload
// s        in   s_tvalid/tready   tdata: address, write_data, line_index, valid_value
//                                 tuser: func
// m        out  m_tvalid/tready   tdata: read_data, mem_address, mem_write_data
//                                 tuser: hit, read_valid, mem_op
//
// The line is read from the line RAM in the accept cycle, and the result is
// formed and written back in the lookup state, which holds while the result
// register is busy; the port takes no new item until the lookup is done.
// After reset a clearing pass writes all LINES entries, one per cycle;
// s_tready stays low meanwhile.
// A stalled result holds the lookup stage and keeps s_tready low until it drains.
// LINES must be a power of two between 2 and 65536.

module direct_mapped_write_through_cache_core #(
  parameter int LINES = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [31:0] address, [63:32] write_data, [75:64] line_index, [76] valid_value
  input  logic [dmwtc_pkg::S_TDATA_W-1:0] s_tdata,
  // [1:0] func
  input  logic [dmwtc_pkg::S_TUSER_W-1:0] s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [31:0] read_data, [63:32] mem_address, [95:64] mem_write_data
  output logic [dmwtc_pkg::M_TDATA_W-1:0] m_tdata,
  // [0] hit, [1] read_valid, [3:2] mem_op
  output logic [dmwtc_pkg::M_TUSER_W-1:0] m_tuser
);

  localparam int IDX_W = $clog2(LINES);
  localparam int TAG_W = dmwtc_pkg::ADDR_W - IDX_W;
  localparam int ENT_W = 1 + TAG_W + dmwtc_pkg::DATA_W;
  localparam int LIX_W = (IDX_W > dmwtc_pkg::LIDX_W) ? IDX_W : dmwtc_pkg::LIDX_W;

  dmwtc_pkg::state_t state, state_next;

  // Captured item
  dmwtc_pkg::func_t                   func_q;
  logic [dmwtc_pkg::ADDR_W-1:0]        addr_q;
  logic signed [dmwtc_pkg::DATA_W-1:0] wdata_q;
  logic [dmwtc_pkg::LIDX_W-1:0]        lidx_q;
  logic                                vval_q;

  // Outstanding miss
  logic [dmwtc_pkg::ADDR_W-1:0] pend_addr;
  logic                         miss_pend;

  // Clearing pass counter
  logic [IDX_W-1:0] clr_cnt;

  // Result register
  logic                                out_hit;
  logic                                out_rv;
  logic signed [dmwtc_pkg::DATA_W-1:0] out_rd;
  dmwtc_pkg::mem_op_t                  out_op;
  logic [dmwtc_pkg::ADDR_W-1:0]        out_maddr;
  logic signed [dmwtc_pkg::DATA_W-1:0] out_mwd;

  // RAM ports
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [ENT_W-1:0] ram_wdata;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  logic [ENT_W-1:0] ram_rdata;

  // Lookup stage signals
  logic                                in_fire;
  logic                                out_free;
  logic                                res_load;
  logic                                ent_valid;
  logic [TAG_W-1:0]                    ent_tag;
  logic signed [dmwtc_pkg::DATA_W-1:0] ent_data;
  logic [LIX_W-1:0]                    s_lidx_ext;
  logic [LIX_W-1:0]                    q_lidx_ext;
  logic                                lidx_in_range;
  logic                                pend_set;
  logic                                pend_clr;

  logic                                res_hit;
  logic                                res_rv;
  logic signed [dmwtc_pkg::DATA_W-1:0] res_rd;
  dmwtc_pkg::mem_op_t                  res_op;
  logic [dmwtc_pkg::ADDR_W-1:0]        res_maddr;
  logic signed [dmwtc_pkg::DATA_W-1:0] res_mwd;

  // Line RAM: {valid, tag, data}
  dmwtc_ram #(
    .WIDTH(ENT_W),
    .DEPTH(LINES)
  ) u_line_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Split the stored entry
  assign ent_data  = ram_rdata[dmwtc_pkg::DATA_W-1:0];
  assign ent_tag   = ram_rdata[dmwtc_pkg::DATA_W +: TAG_W];
  assign ent_valid = ram_rdata[ENT_W-1];

  assign s_lidx_ext    = LIX_W'(s_tdata[75:64]);
  assign q_lidx_ext    = LIX_W'(lidx_q);
  assign lidx_in_range = (32'(lidx_q) < 32'(LINES));

  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      dmwtc_pkg::ST_CLEAR: begin
        if (clr_cnt == IDX_W'(LINES - 1)) begin
          state_next = dmwtc_pkg::ST_IDLE;
        end
      end
      dmwtc_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = dmwtc_pkg::ST_LOOKUP;
        end
      end
      dmwtc_pkg::ST_LOOKUP: begin
        if (out_free) begin
          state_next = dmwtc_pkg::ST_IDLE;
        end
      end
      default: state_next = dmwtc_pkg::ST_CLEAR;
    endcase
  end

  // Handshake, RAM control and result forming
  always_comb begin
    s_tready  = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = addr_q[IDX_W-1:0];
    ram_we    = 1'b0;
    ram_waddr = addr_q[IDX_W-1:0];
    ram_wdata = '0;
    res_load  = 1'b0;
    pend_set  = 1'b0;
    pend_clr  = 1'b0;
    res_hit   = 1'b0;
    res_rv    = 1'b0;
    res_rd    = '0;
    res_op    = dmwtc_pkg::MEM_NONE;
    res_maddr = '0;
    res_mwd   = '0;
    case (state)
      dmwtc_pkg::ST_CLEAR: begin
        // Zero one entry per cycle
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
      end
      dmwtc_pkg::ST_IDLE: begin
        // Read the addressed line as the item is taken
        s_tready = 1'b1;
        ram_re   = s_tvalid;
        if (dmwtc_pkg::func_t'(s_tuser[1:0]) == dmwtc_pkg::FUNC_SET_VALID) begin
          ram_raddr = s_lidx_ext[IDX_W-1:0];
        end else begin
          ram_raddr = s_tdata[IDX_W-1:0];
        end
      end
      dmwtc_pkg::ST_LOOKUP: begin
        res_load = out_free;
        case (func_q)
          dmwtc_pkg::FUNC_READ: begin
            if (ent_valid && ent_tag == addr_q[dmwtc_pkg::ADDR_W-1:IDX_W]) begin
              res_hit = 1'b1;
              res_rv  = 1'b1;
              res_rd  = ent_data;
            end else begin
              res_op    = dmwtc_pkg::MEM_READ;
              res_maddr = addr_q;
              pend_set  = out_free;
            end
          end
          dmwtc_pkg::FUNC_WRITE: begin
            // Allocate the line and pass the word through to memory
            ram_we    = out_free;
            ram_waddr = addr_q[IDX_W-1:0];
            ram_wdata = {1'b1, addr_q[dmwtc_pkg::ADDR_W-1:IDX_W], wdata_q};
            res_op    = dmwtc_pkg::MEM_WRITE;
            res_maddr = addr_q;
            res_mwd   = wdata_q;
          end
          dmwtc_pkg::FUNC_SET_VALID: begin
            // Rewrite the line with only its valid bit changed
            ram_we    = out_free && lidx_in_range;
            ram_waddr = q_lidx_ext[IDX_W-1:0];
            ram_wdata = {vval_q, ent_tag, ent_data};
          end
          dmwtc_pkg::FUNC_FILL: begin
            if (miss_pend) begin
              ram_we    = out_free;
              ram_waddr = pend_addr[IDX_W-1:0];
              ram_wdata = {1'b1, pend_addr[dmwtc_pkg::ADDR_W-1:IDX_W], wdata_q};
              res_rv    = 1'b1;
              res_rd    = wdata_q;
              pend_clr  = out_free;
            end
          end
          default: res_load = out_free;
        endcase
      end
      default: s_tready = 1'b0;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dmwtc_pkg::ST_CLEAR;
      clr_cnt   <= '0;
      miss_pend <= 1'b0;
      pend_addr <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == dmwtc_pkg::ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      // Latest miss wins; a fill retires it
      if (pend_set) begin
        miss_pend <= 1'b1;
        pend_addr <= addr_q;
      end else if (pend_clr) begin
        miss_pend <= 1'b0;
      end
      if (res_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_q  <= dmwtc_pkg::func_t'(s_tuser[1:0]);
      addr_q  <= s_tdata[31:0];
      wdata_q <= s_tdata[63:32];
      lidx_q  <= s_tdata[75:64];
      vval_q  <= s_tdata[76];
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (res_load) begin
      out_hit   <= res_hit;
      out_rv    <= res_rv;
      out_rd    <= res_rd;
      out_op    <= res_op;
      out_maddr <= res_maddr;
      out_mwd   <= res_mwd;
    end
  end

  assign m_tdata = {out_mwd, out_maddr, out_rd};
  assign m_tuser = {out_op, out_rv, out_hit};

endmodule

// File: rtl/dmwtc_checker.sv
`timescale 1ns / 1ps

module dmwtc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [dmwtc_pkg::M_TDATA_W-1:0] m_tdata,
  input logic [dmwtc_pkg::M_TUSER_W-1:0] m_tuser
);

  // Hold a stalled result
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // Keep s_tready low right after reset, as the clearing pass begins
  assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input ready during clearing pass");

  // Close the input for the lookup cycle after each transfer
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready during lookup");

  // A hit returns data and issues no memory request
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |->
      m_tuser[1] && (m_tuser[3:2] == dmwtc_pkg::MEM_NONE))
    else $error("hit without data or with memory request");

  // A memory request never comes with returned data
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && ((m_tuser[3:2] == dmwtc_pkg::MEM_READ) ||
                 (m_tuser[3:2] == dmwtc_pkg::MEM_WRITE)) |-> !m_tuser[1])
    else $error("memory request with read data");

endmodule

bind direct_mapped_write_through_cache_core dmwtc_checker u_checker (.*);
